// ===== src/rrc_pkg.sv =====
`timescale 1ns / 1ps
// Types and constants shared by the request-result cache modules.
// No dependencies.
package rrc_pkg;

  localparam int unsigned TimeW   = 32;
  localparam logic [TimeW-1:0] TtlReset = 32'd5000;

  // request types
  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_STORE  = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // lookup outcomes
  localparam logic [1:0] OUT_MISS     = 2'd0;
  localparam logic [1:0] OUT_FOUND    = 2'd1;
  localparam logic [1:0] OUT_CONFLICT = 2'd2;

  // register map
  localparam logic REG_TTL = 1'b0;

  typedef struct packed {
    logic [7:0]       source;
    logic [7:0]       service;
    logic [7:0]       opcode;
    logic [15:0]      epoch;
    logic [31:0]      request;
    logic [7:0]       stage;
    logic [15:0]      status;
    logic [TimeW-1:0] touched;
  } slot_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture the incoming transaction
    logic clear_all;  // drop every entry
    logic scan;       // scan step
    logic push;       // move the result into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic done;       // scan has settled its outcome
  } sts_t;

endpackage

// ===== src/rrc_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the request-result cache: accept, scan, hand off result.
// Depends on rrc_pkg.
module rrc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    req_type_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rrc_pkg::cmd_t cmd_o,
  input  rrc_pkg::sts_t sts_i
);
  import rrc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_PUSH = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (req_type_i == REQ_LOOKUP || req_type_i == REQ_STORE) begin
            state_d = ST_SCAN;
          end else begin
            cmd_o.clear_all = (req_type_i == REQ_CLEAR);
            state_d = ST_PUSH;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.done) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.push) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== src/rrc_datapath.sv =====
`timescale 1ns / 1ps
// Slot store, scan pipeline (registered read, one slot a cycle) and result
// registers of the request-result cache. Depends on rrc_pkg.
module rrc_datapath #(
  parameter int unsigned SLOTS = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rrc_pkg::cmd_t            cmd_i,
  output rrc_pkg::sts_t            sts_o,
  input  logic [rrc_pkg::TimeW-1:0] ttl_i,
  input  logic [1:0]               req_type_i,
  input  logic [7:0]               source_id_i,
  input  logic [7:0]               service_id_i,
  input  logic [7:0]               op_code_i,
  input  logic [15:0]              session_epoch_i,
  input  logic [31:0]              request_number_i,
  input  logic [7:0]               result_stage_i,
  input  logic [15:0]              result_status_i,
  input  logic [rrc_pkg::TimeW-1:0] now_ms_i,
  output logic [1:0]               outcome_o,
  output logic [7:0]               hit_stage_o,
  output logic [15:0]              hit_status_o
);
  import rrc_pkg::*;

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);
  localparam logic [CntW-1:0] SlotCnt = CntW'(SLOTS);

  // captured transaction
  logic [1:0]       kind_q;
  slot_t            req_q;
  logic [TimeW-1:0] now_q;

  // slot store; valid bits in flops, payload in memory
  slot_t            mem_q [SLOTS];
  logic [SLOTS-1:0] valid_q, valid_d;

  // scan pipeline
  logic [CntW-1:0]  iss_q;
  logic             ev_vld_q;
  logic [IdxW-1:0]  ev_idx_q;
  slot_t            rd_q;
  logic             rd_en;

  // LRU tracking for stores
  logic [IdxW-1:0]  best_idx_q, best_idx_d;
  logic [TimeW-1:0] best_t_q, best_t_d;

  // results
  logic [1:0]  res_outcome_q, res_outcome_d;
  logic [7:0]  res_stage_q, res_stage_d;
  logic [15:0] res_status_q, res_status_d;
  logic [1:0]  out_outcome_q;
  logic [7:0]  out_stage_q;
  logic [15:0] out_status_q;

  // evaluation
  logic             evaluating, v, stale, older, key_eq, attr_eq, first, last, take;
  logic [TimeW-1:0] age, lru_diff;
  logic             done, inval, set_valid, wr_en;
  logic [IdxW-1:0]  wr_addr;
  slot_t            wr_data;

  assign rd_en      = cmd_i.scan && (iss_q != SlotCnt);
  assign evaluating = cmd_i.scan && ev_vld_q;

  always_comb begin
    age      = now_q - rd_q.touched;
    stale    = (age >= ttl_i);
    lru_diff = rd_q.touched - best_t_q;
    older    = lru_diff[TimeW-1];
    v        = valid_q[ev_idx_q];
    key_eq   = (rd_q.source == req_q.source) && (rd_q.epoch == req_q.epoch) &&
               (rd_q.request == req_q.request);
    attr_eq  = (rd_q.service == req_q.service) && (rd_q.opcode == req_q.opcode);
    first    = (ev_idx_q == '0);
    last     = (ev_idx_q == LastIdx);
    take     = first || older;

    done          = 1'b0;
    inval         = 1'b0;
    set_valid     = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = ev_idx_q;
    wr_data       = rd_q;
    best_idx_d    = best_idx_q;
    best_t_d      = best_t_q;
    res_outcome_d = res_outcome_q;
    res_stage_d   = res_stage_q;
    res_status_d  = res_status_q;

    if (cmd_i.load) begin
      res_outcome_d = OUT_MISS;
      res_stage_d   = '0;
      res_status_d  = '0;
    end else if (evaluating) begin
      if (kind_q == REQ_LOOKUP) begin
        // expired entries passed on the way are dropped
        if (v && stale) begin
          inval = 1'b1;
        end
        if (v && !stale && key_eq) begin
          done = 1'b1;
          if (attr_eq) begin
            wr_en           = 1'b1;
            wr_data.touched = now_q;
            res_outcome_d   = OUT_FOUND;
            res_stage_d     = rd_q.stage;
            res_status_d    = rd_q.status;
          end else begin
            res_outcome_d = OUT_CONFLICT;
          end
        end else if (last) begin
          done = 1'b1;
        end
      end else begin
        // store: first free or expired slot, else oldest touch
        wr_data         = req_q;
        wr_data.touched = now_q;
        if (!v || stale) begin
          done = 1'b1;
        end else begin
          if (take) begin
            best_idx_d = ev_idx_q;
            best_t_d   = rd_q.touched;
          end
          if (last) begin
            done    = 1'b1;
            wr_addr = take ? ev_idx_q : best_idx_q;
          end
        end
        wr_en     = done;
        set_valid = done;
      end
    end
  end

  assign sts_o.done = evaluating && done;

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.clear_all) begin
      valid_d = '0;
    end else begin
      if (inval) begin
        valid_d[ev_idx_q] = 1'b0;
      end
      if (set_valid) begin
        valid_d[wr_addr] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      iss_q    <= '0;
      ev_vld_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (cmd_i.load) begin
        iss_q    <= '0;
        ev_vld_q <= 1'b0;
      end else if (cmd_i.scan) begin
        ev_vld_q <= rd_en;
        if (rd_en) begin
          iss_q <= iss_q + 1'b1;
        end
      end
    end
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q     <= mem_q[iss_q[IdxW-1:0]];
      ev_idx_q <= iss_q[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q          <= req_type_i;
      req_q.source    <= source_id_i;
      req_q.service   <= service_id_i;
      req_q.opcode    <= op_code_i;
      req_q.epoch     <= session_epoch_i;
      req_q.request   <= request_number_i;
      req_q.stage     <= result_stage_i;
      req_q.status    <= result_status_i;
      req_q.touched   <= now_ms_i;
      now_q           <= now_ms_i;
    end
    best_idx_q    <= best_idx_d;
    best_t_q      <= best_t_d;
    res_outcome_q <= res_outcome_d;
    res_stage_q   <= res_stage_d;
    res_status_q  <= res_status_d;
    if (cmd_i.push) begin
      out_outcome_q <= res_outcome_q;
      out_stage_q   <= res_stage_q;
      out_status_q  <= res_status_q;
    end
  end

  assign outcome_o    = out_outcome_q;
  assign hit_stage_o  = out_stage_q;
  assign hit_status_o = out_status_q;

endmodule

// ===== src/request_result_cache_ttl_lru_top.sv =====
`timescale 1ns / 1ps
// Request-result cache with TTL expiry and LRU replacement; top level.
// Depends on rrc_pkg, rrc_ctrl and rrc_datapath.
//
// Caches request results keyed by source, epoch and request number in SLOTS
// entries. One transaction is handled at a time: a lookup or store scans the
// slot memory one entry a cycle through its single registered read port, then
// passes its result through the push state into the output register; clear
// and the unused request type go from acceptance straight to the push state,
// which waits while the held output register is stalled. Lookups drop expired
// entries they pass and stop at the first key match; stores take the first
// free or expired slot, else the least recently touched. Every transaction
// gives exactly one result. The result sits in an output register, so a new
// transaction is accepted while it waits. ttl_ms (reset 5000) is at APB byte
// address 0 and is to be written only while idle; the block does not check.
module request_result_cache_ttl_lru_top #(
  parameter int unsigned SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  source_id_i,
  input  logic [7:0]  service_id_i,
  input  logic [7:0]  op_code_i,
  input  logic [15:0] session_epoch_i,
  input  logic [31:0] request_number_i,
  input  logic [7:0]  result_stage_i,
  input  logic [15:0] result_status_i,
  input  logic [31:0] now_ms_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  outcome_o,
  output logic [7:0]  hit_stage_o,
  output logic [15:0] hit_status_o
);
  import rrc_pkg::*;

  logic [TimeW-1:0] ttl_q;
  logic             cfg_wr;
  cmd_t             cmd;
  sts_t             sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TTL);
  assign prdata = (paddr[2] == REG_TTL) ? ttl_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q <= TtlReset;
    end else if (cfg_wr) begin
      ttl_q <= pwdata;
    end
  end

  rrc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  rrc_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .ttl_i            (ttl_q),
    .req_type_i       (req_type_i),
    .source_id_i      (source_id_i),
    .service_id_i     (service_id_i),
    .op_code_i        (op_code_i),
    .session_epoch_i  (session_epoch_i),
    .request_number_i (request_number_i),
    .result_stage_i   (result_stage_i),
    .result_status_i  (result_status_i),
    .now_ms_i         (now_ms_i),
    .outcome_o        (outcome_o),
    .hit_stage_o      (hit_stage_o),
    .hit_status_o     (hit_status_o)
  );

endmodule
